// File: rtl/core/ibc_pkg.sv
// Shared types and constants for the IMU bias calibration and correction core.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
`default_nettype none

package ibc_pkg;

  // Field widths fixed by the sample format.
  localparam int SAMPLE_W = 16;
  localparam int NUM_AXES = 3;
  localparam int SUM_W    = 25;
  localparam int GRAV_W   = 15;
  localparam int CNT_W    = 8;

  // Reset value of the one-g count for the Z accelerometer axis.
  localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd8196;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One input word: raw samples plus the calibration request.
  typedef struct packed {
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
    sample_t rate_x;
    sample_t rate_y;
    sample_t rate_z;
    logic    start_calibration;
  } in_word_t;

  // One output word: corrected samples plus calibration status.
  typedef struct packed {
    sample_t accel_x_corrected;
    sample_t accel_y_corrected;
    sample_t accel_z_corrected;
    sample_t rate_x_corrected;
    sample_t rate_y_corrected;
    sample_t rate_z_corrected;
    logic    gyro_cal_busy;
    logic    accel_cal_busy;
  } out_word_t;

  // Per-word commands from the sequencer to every axis lane.
  typedef struct packed {
    logic sum_clear;
    logic sum_add;
    logic add_accel;
    logic rate_off_clear;
    logic accel_off_clear;
    logic div_load;
    logic div_mul;
    logic div_wr_rate;
    logic div_wr_accel;
  } lane_ctl_t;

  // Calibration status that travels with each output word.
  typedef struct packed {
    logic gyro_busy;
    logic accel_busy;
  } cal_status_t;

endpackage

`default_nettype wire

// File: rtl/core/imu_bias_calibrate_and_correct_core.sv
// Top level of the IMU bias calibration and correction core.
// Depends on ibc_pkg, ibc_lane, ibc_ctrl and ibc_merge.
`default_nettype none

// The core takes one word of six raw IMU samples per clock cycle while
// in_stall is low and returns, from its output register, each sample minus
// its stored offset together with the gyro and accel calibration busy flags.
// A start request runs gyro calibration over AVERAGE_COUNT words and then
// accel calibration over the next AVERAGE_COUNT words, the two overlapping on
// one word. Three axis lanes work side by side, each with its own offsets,
// accumulator and reciprocal multiplier, and a merging stage with a two-entry
// output buffer collects their results. Throughput is one word per cycle
// while the input is not stalled; after the last word of each calibration
// the input stalls while each lane's multiplier turns its axis sum into the
// new offset. A result waiting at the output does not block the next word.
// gravity_counts may be written only while the core is idle.
module imu_bias_calibrate_and_correct_core #(
  parameter int AVERAGE_COUNT = 200
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ibc_pkg::in_word_t           in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ibc_pkg::out_word_t               out_word,
  input  wire logic                        cfg_wen,
  input  wire logic [ibc_pkg::GRAV_W-1:0]  cfg_wdata
);

  logic [ibc_pkg::GRAV_W-1:0] gravity_counts;
  logic                       accept;
  logic                       div_busy;
  logic                       skid_full;
  ibc_pkg::lane_ctl_t         ctl;
  ibc_pkg::cal_status_t       status;
  ibc_pkg::sample_t           accel_in   [ibc_pkg::NUM_AXES];
  ibc_pkg::sample_t           rate_in    [ibc_pkg::NUM_AXES];
  ibc_pkg::sample_t           accel_corr [ibc_pkg::NUM_AXES];
  ibc_pkg::sample_t           rate_corr  [ibc_pkg::NUM_AXES];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_counts <= ibc_pkg::GRAVITY_RESET;
    end else if (cfg_wen) begin
      gravity_counts <= cfg_wdata;
    end
  end

  // Input handshake.
  assign in_stall = skid_full || div_busy;
  assign accept   = in_valid && !in_stall;

  assign accel_in[0] = in_word.accel_x;
  assign accel_in[1] = in_word.accel_y;
  assign accel_in[2] = in_word.accel_z;
  assign rate_in[0]  = in_word.rate_x;
  assign rate_in[1]  = in_word.rate_y;
  assign rate_in[2]  = in_word.rate_z;

  ibc_ctrl #(
    .AVERAGE_COUNT(AVERAGE_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .start   (in_word.start_calibration),
    .ctl     (ctl),
    .status  (status),
    .div_busy(div_busy)
  );

  // One lane per axis; only the Z lane sees the gravity count.
  for (genvar i = 0; i < ibc_pkg::NUM_AXES; i++) begin : g_lane
    logic [ibc_pkg::GRAV_W-1:0] lane_bias;
    assign lane_bias = (i == ibc_pkg::NUM_AXES - 1) ? gravity_counts : '0;

    ibc_lane #(
      .AVERAGE_COUNT(AVERAGE_COUNT)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .accel     (accel_in[i]),
      .rate      (rate_in[i]),
      .bias      (lane_bias),
      .accel_corr(accel_corr[i]),
      .rate_corr (rate_corr[i])
    );
  end

  ibc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .accel_corr(accel_corr),
    .rate_corr (rate_corr),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .skid_full (skid_full)
  );

endmodule

`default_nettype wire

// File: rtl/core/ibc_lane.sv
// One axis lane: offset correction, axis accumulator and reciprocal divider.
// Depends on ibc_pkg for widths and the lane command struct.
`default_nettype none

module ibc_lane #(
  parameter int AVERAGE_COUNT = 200
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ibc_pkg::lane_ctl_t            ctl,
  input  wire ibc_pkg::sample_t              accel,
  input  wire ibc_pkg::sample_t              rate,
  input  wire logic [ibc_pkg::GRAV_W-1:0]    bias,
  output ibc_pkg::sample_t                   accel_corr,
  output ibc_pkg::sample_t                   rate_corr
);

  localparam int SW     = ibc_pkg::SAMPLE_W;
  localparam int SUM_W  = ibc_pkg::SUM_W;
  localparam int PROD_W = 2 * SUM_W;
  // The magnitude of a sum stays below 2^(SUM_W-1), so this shift makes the
  // rounded-up reciprocal exact for every reachable sum.
  localparam int SHIFT  = SUM_W - 1 + $clog2(AVERAGE_COUNT);
  localparam logic [PROD_W-1:0] RECIP_FULL =
    ((PROD_W'(1) << SHIFT) + PROD_W'(AVERAGE_COUNT) - PROD_W'(1)) / PROD_W'(AVERAGE_COUNT);
  localparam logic [SUM_W-1:0] RECIP = RECIP_FULL[SUM_W-1:0];

  logic [SW-1:0]          accel_off;
  logic [SW-1:0]          rate_off;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] div_sum;
  logic                   div_neg;
  logic [PROD_W-1:0]      product;

  logic [SW:0]            src_ext;
  logic [SW:0]            bias_ext;
  logic [SW:0]            addend;
  logic signed [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0]       div_mag;
  logic [SW-1:0]          quot;
  logic [SW-1:0]          off_next;

  // Correction with the offsets held when the word arrives.
  assign accel_corr = ibc_pkg::sample_t'(accel - accel_off);
  assign rate_corr  = ibc_pkg::sample_t'(rate - rate_off);

  // Addend for the accumulator; the bias applies only to accelerometer data.
  always_comb begin
    if (ctl.add_accel) begin
      src_ext  = {accel_corr[SW-1], accel_corr};
      bias_ext = {2'b00, bias};
    end else begin
      src_ext  = {rate_corr[SW-1], rate_corr};
      bias_ext = '0;
    end
    addend   = src_ext - bias_ext;
    sum_next = sum + $signed({{(SUM_W-SW-1){addend[SW]}}, addend});
  end

  // Axis accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.sum_clear) begin
      sum <= '0;
    end else if (ctl.sum_add) begin
      sum <= sum_next;
    end
  end

  // Divider: capture the final sum, multiply its magnitude by the reciprocal.
  assign div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      div_sum <= sum_next;
    end
    if (ctl.div_mul) begin
      div_neg <= div_sum[SUM_W-1];
      product <= PROD_W'(div_mag) * PROD_W'(RECIP);
    end
  end

  // Quotient truncated toward zero, wrapped to the sample width.
  always_comb begin
    quot     = product[SHIFT +: SW];
    off_next = div_neg ? SW'(-quot) : quot;
  end

  // Offset registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_off <= '0;
      rate_off  <= '0;
    end else begin
      if (ctl.rate_off_clear) begin
        rate_off <= '0;
      end else if (ctl.div_wr_rate) begin
        rate_off <= off_next;
      end
      if (ctl.accel_off_clear) begin
        accel_off <= '0;
      end else if (ctl.div_wr_accel) begin
        accel_off <= off_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ibc_ctrl.sv
// Calibration sequencer: sample counter, pending flags and divider timing.
// Depends on ibc_pkg for the lane command and status structs.
`default_nettype none

module ibc_ctrl #(
  parameter int AVERAGE_COUNT = 200
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  start,
  output ibc_pkg::lane_ctl_t         ctl,
  output ibc_pkg::cal_status_t       status,
  output logic                       div_busy
);

  localparam int CW = ibc_pkg::CNT_W;
  localparam logic [CW-1:0] AVG_CNT = CW'(AVERAGE_COUNT);

  logic [CW-1:0] cnt;
  logic          gyro_pending;
  logic          accel_pending;
  logic          div1_valid;
  logic          div1_accel;
  logic          div2_valid;
  logic          div2_accel;

  logic          gyro_run;
  logic          gyro_clear;
  logic          gyro_fin;
  logic          accel_run;
  logic          accel_clear;
  logic          accel_fin;
  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic [CW-1:0] cnt_c;
  logic [CW-1:0] cnt_next;
  logic          gyro_pending_next;
  logic          accel_pending_next;

  // Gyro phase first, then the accel phase, sharing one counter.
  always_comb begin
    gyro_run   = gyro_pending || (start && !gyro_pending && !accel_pending);
    gyro_clear = gyro_run && (cnt == '0);
    cnt_a      = gyro_clear ? CW'(1) : cnt;
    gyro_fin   = gyro_run && (cnt_a == AVG_CNT);
    if (gyro_run) begin
      cnt_b = gyro_fin ? '0 : cnt_a + CW'(1);
    end else begin
      cnt_b = cnt;
    end

    accel_run   = accel_pending || gyro_fin;
    accel_clear = accel_run && (cnt_b == '0);
    cnt_c       = accel_clear ? CW'(1) : cnt_b;
    accel_fin   = accel_run && (cnt_c == AVG_CNT);
    if (accel_run) begin
      cnt_next = accel_fin ? '0 : cnt_c + CW'(1);
    end else begin
      cnt_next = cnt_b;
    end

    gyro_pending_next  = gyro_run && !gyro_fin;
    accel_pending_next = accel_run && !accel_fin;
  end

  // Commands to the lanes.
  always_comb begin
    ctl.sum_clear       = accept && (gyro_clear || accel_clear);
    ctl.sum_add         = accept && ((gyro_run && !gyro_clear) || (accel_run && !accel_clear));
    ctl.add_accel       = accel_run && !accel_clear;
    ctl.rate_off_clear  = accept && gyro_clear;
    ctl.accel_off_clear = accept && accel_clear;
    ctl.div_load        = accept && (gyro_fin || accel_fin);
    ctl.div_mul         = div1_valid;
    ctl.div_wr_rate     = div2_valid && !div2_accel;
    ctl.div_wr_accel    = div2_valid && div2_accel;
  end

  assign status.gyro_busy  = gyro_pending_next;
  assign status.accel_busy = accel_pending_next;
  assign div_busy          = div1_valid || div2_valid;

  // Sequencer state and divider pipeline tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      gyro_pending  <= 1'b0;
      accel_pending <= 1'b0;
      div1_valid    <= 1'b0;
      div1_accel    <= 1'b0;
      div2_valid    <= 1'b0;
      div2_accel    <= 1'b0;
    end else begin
      if (accept) begin
        cnt           <= cnt_next;
        gyro_pending  <= gyro_pending_next;
        accel_pending <= accel_pending_next;
      end
      div1_valid <= accept && (gyro_fin || accel_fin);
      div1_accel <= accel_fin;
      div2_valid <= div1_valid;
      div2_accel <= div1_accel;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ibc_merge.sv
// Merging stage: gathers the lane results into one word, with output skid.
// Depends on ibc_pkg for the sample, status and output word types.
`default_nettype none

module ibc_merge (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire ibc_pkg::sample_t       accel_corr [ibc_pkg::NUM_AXES],
  input  wire ibc_pkg::sample_t       rate_corr [ibc_pkg::NUM_AXES],
  input  wire ibc_pkg::cal_status_t   status,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output ibc_pkg::out_word_t          out_word,
  output logic                        skid_full
);

  ibc_pkg::out_word_t new_word;
  ibc_pkg::out_word_t skid_word;
  logic               skid_valid;
  logic               slot_free;
  logic               out_valid_next;
  logic               skid_valid_next;
  logic               load_from_skid;
  logic               load_from_new;
  logic               load_skid;

  // Assemble the word from the three lanes.
  always_comb begin
    new_word.accel_x_corrected = accel_corr[0];
    new_word.accel_y_corrected = accel_corr[1];
    new_word.accel_z_corrected = accel_corr[2];
    new_word.rate_x_corrected  = rate_corr[0];
    new_word.rate_y_corrected  = rate_corr[1];
    new_word.rate_z_corrected  = rate_corr[2];
    new_word.gyro_cal_busy     = status.gyro_busy;
    new_word.accel_cal_busy    = status.accel_busy;
  end

  // Output register plus one skid entry.
  always_comb begin
    slot_free       = !out_valid || !out_stall;
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    load_from_skid  = 1'b0;
    load_from_new   = 1'b0;
    load_skid       = 1'b0;
    if (skid_valid) begin
      if (slot_free) begin
        load_from_skid  = 1'b1;
        out_valid_next  = 1'b1;
        skid_valid_next = accept;
        load_skid       = accept;
      end
    end else if (slot_free) begin
      out_valid_next = accept;
      load_from_new  = accept;
    end else begin
      skid_valid_next = accept;
      load_skid       = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_word <= skid_word;
    end else if (load_from_new) begin
      out_word <= new_word;
    end
    if (load_skid) begin
      skid_word <= new_word;
    end
  end

  assign skid_full = skid_valid;

endmodule

`default_nettype wire

// File: rtl/core/ibc_checker.sv
// Port-level checker for the IMU bias calibration core, bound to the top level.
// Depends on ibc_pkg for the word types.
`default_nettype none

module ibc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire ibc_pkg::out_word_t          out_word
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // Gyro and accel calibration are never both pending.
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.gyro_cal_busy && out_word.accel_cal_busy))
    else $error("both calibrations pending");

  // A word accepted into an empty output appears on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && !out_valid |=> out_valid)
    else $error("accepted word did not reach the output");

  // With the output empty, only a recent word can hold the input off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(in_acc) && !$past(in_acc, 2) |-> !in_stall)
    else $error("input stalled with nothing in flight");

endmodule

bind imu_bias_calibrate_and_correct_core ibc_checker u_checker (.*);

`default_nettype wire
